@@ rtl/assert_macros.svh @@
// Assertion macros used by the top level of the SD card SPI host controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("implication check failed");
// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

@@ rtl/sdh_pkg.sv @@
// Package with types, constants and helper functions of the SD card SPI host controller.
`default_nettype none
package sdh_pkg;

  localparam int unsigned SECTOR_BYTES    = 512;
  localparam int unsigned REINIT_LIMIT    = 3;
  localparam int unsigned PRESIGNAL_BYTES = 12;
  localparam int unsigned CMD_RETRIES     = 100;

  localparam int unsigned BC_W  = 10;
  localparam int unsigned WC_W  = 17;
  localparam int unsigned CNT_W = 7;

  localparam logic [1:0] CMD_EXCH  = 2'd0;
  localparam logic [1:0] CMD_INIT  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_WRITE = 2'd3;

  localparam logic [2:0] REG_READY_TO   = 3'd0;
  localparam logic [2:0] REG_RESP_TO    = 3'd1;
  localparam logic [2:0] REG_TOKEN_TO   = 3'd2;
  localparam logic [2:0] REG_BUSY_TO    = 3'd3;
  localparam logic [2:0] REG_INIT_TRIES = 3'd4;
  localparam logic [2:0] REG_ACMD_TRIES = 3'd5;
  localparam logic [2:0] REG_READ_RETRY = 3'd6;
  localparam logic [2:0] REG_CRC_EN     = 3'd7;

  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_NOT_READY = 4'd1;
  localparam logic [3:0] ST_RESET     = 4'd2;
  localparam logic [3:0] ST_CMD8      = 4'd3;
  localparam logic [3:0] ST_IDENT     = 4'd4;
  localparam logic [3:0] ST_REJECTED  = 4'd5;
  localparam logic [3:0] ST_TOKEN     = 4'd6;
  localparam logic [3:0] ST_CRC       = 4'd7;
  localparam logic [3:0] ST_BUSY      = 4'd8;

  localparam logic [7:0] BYTE_IDLE  = 8'hFF;
  localparam logic [7:0] BYTE_TOKEN = 8'hFE;
  localparam logic [7:0] R1_IDLE    = 8'h01;
  localparam logic [7:0] R1_READY   = 8'h00;
  localparam logic [7:0] R1_ADDRERR = 8'h04;

  localparam logic [55:0] F_CMD0  = 56'h0040_0000_0000_95;
  localparam logic [55:0] F_CMD8  = 56'hFF_48_0000_01AA_87;
  localparam logic [55:0] F_CMD55 = 56'hFF_77_0000_0000_FF;
  localparam logic [55:0] F_ACMD41 = 56'hFF_69_4000_0000_87;
  localparam logic [55:0] F_CMD58 = 56'hFF_7A_0000_0000_75;
  localparam logic [55:0] F_CMD1  = 56'h0050_0000_0200_FF;
  localparam logic [7:0]  OP_CMD17 = 8'h51;
  localparam logic [7:0]  OP_CMD24 = 8'h58;

  typedef enum logic [14:0] {
    PH_IDLE  = 15'b000000000000001,
    PH_PRE   = 15'b000000000000010,
    PH_READY = 15'b000000000000100,
    PH_TOG1  = 15'b000000000001000,
    PH_TOG2  = 15'b000000000010000,
    PH_FRAME = 15'b000000000100000,
    PH_RESP  = 15'b000000001000000,
    PH_EXTRA = 15'b000000010000000,
    PH_TOKEN = 15'b000000100000000,
    PH_RDATA = 15'b000001000000000,
    PH_RCRC  = 15'b000010000000000,
    PH_WGAP  = 15'b000100000000000,
    PH_WDATA = 15'b001000000000000,
    PH_WCRC  = 15'b010000000000000,
    PH_BUSY  = 15'b100000000000000
  } phase_t;

  typedef enum logic [4:0] {
    K_INIT_READY, K_INIT_SEL, K_C0, K_C8, K_C55, K_A41, K_C58, K_C1, K_INIT_OK,
    K_CSEL, K_CREADY, K_CREL, K_RSEL, K_RCMD, K_RFAIL, K_REND, K_WCMD, K_WFAIL, K_WEND
  } key_t;

  typedef enum logic [1:0] {OP_NONE, OP_INIT, OP_READ, OP_WRITE} op_t;

  typedef struct packed {
    logic [15:0] ready_to;
    logic [15:0] resp_to;
    logic [16:0] token_to;
    logic [16:0] busy_to;
    logic [6:0]  init_tries;
    logic [6:0]  acmd_tries;
    logic [6:0]  read_retries;
    logic        crc_en;
  } cfg_t;

  typedef struct packed {
    logic [7:0] mosi_byte;
    logic       exchange_request;
    logic       chip_select;
    logic       slow_clock;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       write_request;
    logic       done_res;
    logic       success;
    logic       card_is_sdhc;
    logic [3:0] status_code;
  } res_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic [7:0] frame_byte(input logic [55:0] frame, input logic [2:0] len,
                                            input logic [BC_W-1:0] i);
    logic [2:0]  idx;
    logic [63:0] wide;
    idx  = len - 3'd1 - i[2:0];
    wide = {8'h00, frame} >> {idx, 3'b000};
    return wide[7:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/sdh_seq.sv @@
// Command and data sequencer of the SD card SPI host controller, one exchange per step.
`default_nettype none
module sdh_seq (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 step,
  input  wire logic [1:0]           cmd,
  input  wire logic [31:0]          block_address,
  input  wire logic [7:0]           write_byte,
  input  wire logic [7:0]           miso_byte,
  input  wire sdh_pkg::cfg_t        cfg,
  output sdh_pkg::res_t             res
);
  import sdh_pkg::*;

  phase_t          ph_r, ph_nxt;
  logic [BC_W-1:0] bc_r, bc_nxt;
  logic [WC_W-1:0] wc_r, wc_nxt;
  logic [CNT_W-1:0] att_r, att_nxt;
  logic [1:0]      reinit_r, reinit_nxt;
  logic            sdhc_r, sdhc_nxt;
  logic [55:0]     frame_r, frame_nxt;
  logic [15:0]     crc_r, crc_nxt;
  logic [15:0]     rcrc_r, rcrc_nxt;
  logic [31:0]     addr_r, addr_nxt;
  logic [7:0]      lr_r, lr_nxt;
  op_t             op_r, op_nxt;
  key_t            leaf_r, leaf_nxt;
  key_t            cret_r, cret_nxt;
  logic            tog_r, tog_nxt;
  logic            cs_r, cs_nxt;
  logic            slow_r, slow_nxt;
  logic [2:0]      flen_r, flen_nxt;
  logic [2:0]      xlen_r, xlen_nxt;
  logic [7:0]      expect_r, expect_nxt;
  logic            rel_r, rel_nxt;
  logic [CNT_W-1:0] cleft_r, cleft_nxt;
  logic [CNT_W-1:0] aleft_r, aleft_nxt;
  logic [CNT_W-1:0] rleft_r, rleft_nxt;
  logic [7:0]      ocr_r, ocr_nxt;
  logic [3:0]      fail_r, fail_nxt;
  logic            busy_r, busy_nxt;

  always_comb begin
    logic        emit, rdy, do_res, do_cnext, do_cend, do_anext, do_ifail, do_rfail;
    logic        do_iend, iend_ok, do_cgo, cg_rel, do_tog, tg_lvl, fin, fin_ok;
    logic [7:0]  emit_b, cg_exp, r;
    logic [3:0]  ifail_code, iend_code, fin_code;
    logic [55:0] cg_frame;
    logic [2:0]  cg_len, cg_xlen;
    logic [31:0] card_addr;
    key_t        rk, cg_k, tg_k;

    ph_nxt = ph_r; bc_nxt = bc_r; wc_nxt = wc_r; att_nxt = att_r; reinit_nxt = reinit_r;
    sdhc_nxt = sdhc_r; frame_nxt = frame_r; crc_nxt = crc_r; rcrc_nxt = rcrc_r;
    addr_nxt = addr_r; lr_nxt = lr_r; op_nxt = op_r; leaf_nxt = leaf_r; cret_nxt = cret_r;
    tog_nxt = tog_r; cs_nxt = cs_r; slow_nxt = slow_r; flen_nxt = flen_r; xlen_nxt = xlen_r;
    expect_nxt = expect_r; rel_nxt = rel_r; cleft_nxt = cleft_r; aleft_nxt = aleft_r;
    rleft_nxt = rleft_r; ocr_nxt = ocr_r; fail_nxt = fail_r; busy_nxt = busy_r;

    res = '0;
    emit = 1'b0; emit_b = BYTE_IDLE; rdy = 1'b0; do_res = 1'b0; rk = K_INIT_READY;
    do_cnext = 1'b0; do_cend = 1'b0; do_anext = 1'b0; do_ifail = 1'b0; ifail_code = ST_OK;
    do_rfail = 1'b0; do_iend = 1'b0; iend_ok = 1'b0; iend_code = ST_OK;
    do_cgo = 1'b0; cg_frame = '0; cg_len = 3'd6; cg_xlen = 3'd0; cg_exp = R1_READY;
    cg_rel = 1'b0; cg_k = K_C0; do_tog = 1'b0; tg_lvl = 1'b0; tg_k = K_CSEL;
    fin = 1'b0; fin_ok = 1'b0; fin_code = ST_OK; r = 8'h00; card_addr = '0;

    if (step) begin
      // Start commands restart the sequencer whatever it was doing.
      case (cmd)
        CMD_INIT: begin
          op_nxt = OP_INIT; att_nxt = '0; slow_nxt = 1'b1;
          bc_nxt = '0; cs_nxt = 1'b1; ph_nxt = PH_PRE; emit = 1'b1;
        end
        CMD_READ: begin
          op_nxt = OP_READ; addr_nxt = block_address; cs_nxt = 1'b0;
          rleft_nxt = cfg.read_retries; reinit_nxt = '0;
          do_tog = 1'b1; tg_lvl = 1'b0; tg_k = K_RSEL;
        end
        CMD_WRITE: begin
          op_nxt = OP_WRITE; addr_nxt = block_address;
          card_addr = sdhc_r ? block_address : {block_address[22:0], 9'd0};
          do_cgo = 1'b1; cg_frame = {8'hFF, OP_CMD24, card_addr, 8'hFF}; cg_len = 3'd7;
          cg_xlen = 3'd0; cg_exp = R1_READY; cg_rel = 1'b0; cg_k = K_WCMD;
        end
        default: begin
          case (ph_r)
            PH_IDLE: ;
            PH_PRE: begin
              bc_nxt = bc_r + 1'b1;
              if (bc_nxt < BC_W'(PRESIGNAL_BYTES)) emit = 1'b1;
              else begin
                leaf_nxt = K_INIT_READY; wc_nxt = '0; ph_nxt = PH_READY; emit = 1'b1;
              end
            end
            PH_READY: begin
              wc_nxt = wc_r + 1'b1;
              if (miso_byte == BYTE_IDLE) begin
                rdy = 1'b1; do_res = 1'b1; rk = leaf_r;
              end else if (wc_nxt >= {1'b0, cfg.ready_to}) begin
                do_res = 1'b1; rk = leaf_r;
              end else emit = 1'b1;
            end
            PH_TOG1: begin
              cs_nxt = tog_r; ph_nxt = PH_TOG2; emit = 1'b1;
            end
            PH_TOG2: begin
              do_res = 1'b1; rk = leaf_r;
            end
            PH_FRAME: begin
              bc_nxt = bc_r + 1'b1;
              if (bc_nxt < BC_W'(flen_r)) begin
                emit = 1'b1; emit_b = frame_byte(frame_r, flen_r, bc_nxt);
              end else begin
                wc_nxt = '0; ph_nxt = PH_RESP; emit = 1'b1;
              end
            end
            PH_RESP: begin
              wc_nxt = wc_r + 1'b1;
              if (miso_byte != BYTE_IDLE) begin
                lr_nxt = miso_byte;
                if (xlen_r != 3'd0) begin
                  bc_nxt = '0; ph_nxt = PH_EXTRA; emit = 1'b1;
                end else if (miso_byte == expect_r) do_cend = 1'b1;
                else do_cnext = 1'b1;
              end else if (wc_nxt >= {1'b0, cfg.resp_to}) begin
                lr_nxt = BYTE_IDLE; do_cend = 1'b1;
              end else emit = 1'b1;
            end
            PH_EXTRA: begin
              if (bc_r == '0) ocr_nxt = miso_byte;
              bc_nxt = bc_r + 1'b1;
              if (bc_nxt < BC_W'(xlen_r)) emit = 1'b1;
              else if (lr_r == expect_r) do_cend = 1'b1;
              else do_cnext = 1'b1;
            end
            PH_TOKEN: begin
              wc_nxt = wc_r + 1'b1;
              if (miso_byte == BYTE_TOKEN) begin
                bc_nxt = '0; crc_nxt = '0; ph_nxt = PH_RDATA; emit = 1'b1;
              end else if (wc_nxt >= cfg.token_to) begin
                fail_nxt = ST_TOKEN; do_tog = 1'b1; tg_lvl = 1'b1; tg_k = K_RFAIL;
              end else emit = 1'b1;
            end
            PH_RDATA: begin
              res.read_valid = 1'b1; res.read_byte = miso_byte;
              crc_nxt = crc16_byte(crc_r, miso_byte);
              bc_nxt = bc_r + 1'b1;
              if (bc_nxt >= BC_W'(SECTOR_BYTES)) begin
                bc_nxt = '0; rcrc_nxt = '0; ph_nxt = PH_RCRC;
              end
              emit = 1'b1;
            end
            PH_RCRC: begin
              rcrc_nxt = {rcrc_r[7:0], miso_byte};
              bc_nxt = bc_r + 1'b1;
              if (bc_nxt < BC_W'(2)) emit = 1'b1;
              else begin
                do_tog = 1'b1; tg_lvl = 1'b1; tg_k = K_REND;
              end
            end
            PH_WGAP: begin
              if (bc_r == '0) begin
                bc_nxt = BC_W'(1); emit = 1'b1; emit_b = BYTE_TOKEN; res.write_request = 1'b1;
              end else begin
                // The first data byte goes out right after the token.
                ph_nxt = PH_WDATA; emit = 1'b1; emit_b = write_byte;
                bc_nxt = BC_W'(1); res.write_request = 1'b1;
              end
            end
            PH_WDATA: begin
              if (bc_r < BC_W'(SECTOR_BYTES)) begin
                emit = 1'b1; emit_b = write_byte; bc_nxt = bc_r + 1'b1;
                if (bc_nxt < BC_W'(SECTOR_BYTES)) res.write_request = 1'b1;
              end else begin
                bc_nxt = BC_W'(1); ph_nxt = PH_WCRC; emit = 1'b1;
              end
            end
            PH_WCRC: begin
              emit = 1'b1;
              if (bc_r < BC_W'(3)) bc_nxt = bc_r + 1'b1;
              else begin
                wc_nxt = '0; ph_nxt = PH_BUSY;
              end
            end
            PH_BUSY: begin
              wc_nxt = wc_r + 1'b1;
              if (miso_byte != 8'h00) begin
                busy_nxt = 1'b1; do_tog = 1'b1; tg_lvl = 1'b1; tg_k = K_WEND;
              end else if (wc_nxt >= cfg.busy_to) begin
                busy_nxt = 1'b0; do_tog = 1'b1; tg_lvl = 1'b1; tg_k = K_WEND;
              end else emit = 1'b1;
            end
            default: ph_nxt = PH_IDLE;
          endcase
        end
      endcase

      // Command-level continuations.
      if (do_res && rk == K_CREL) rk = cret_r;
      if (do_res && rk == K_CSEL) begin
        do_res = 1'b0; leaf_nxt = K_CREADY; wc_nxt = '0; ph_nxt = PH_READY; emit = 1'b1;
      end
      if (do_res && rk == K_CREADY) begin
        do_res = 1'b0;
        if (rdy) begin
          bc_nxt = '0; ph_nxt = PH_FRAME; emit = 1'b1;
          emit_b = frame_byte(frame_r, flen_r, '0);
        end else begin
          cs_nxt = 1'b1; do_cnext = 1'b1;
        end
      end
      if (do_cnext) begin
        if (cleft_r > CNT_W'(1)) begin
          cleft_nxt = cleft_r - 1'b1; do_tog = 1'b1; tg_lvl = 1'b0; tg_k = K_CSEL;
        end else do_cend = 1'b1;
      end
      if (do_cend) begin
        if (rel_r) begin
          do_tog = 1'b1; tg_lvl = 1'b1; tg_k = K_CREL;
        end else begin
          do_res = 1'b1; rk = cret_r;
        end
      end

      // Operation-level continuations.
      r = lr_nxt;
      if (do_res) begin
        case (rk)
          K_INIT_READY: begin
            if (rdy) begin
              do_tog = 1'b1; tg_lvl = 1'b0; tg_k = K_INIT_SEL;
            end else begin
              do_ifail = 1'b1; ifail_code = ST_NOT_READY;
            end
          end
          K_INIT_SEL: begin
            do_cgo = 1'b1; cg_frame = F_CMD0; cg_len = 3'd6; cg_xlen = 3'd0;
            cg_exp = R1_IDLE; cg_rel = 1'b1; cg_k = K_C0;
          end
          K_C0: begin
            if (r == R1_IDLE) begin
              do_cgo = 1'b1; cg_frame = F_CMD8; cg_len = 3'd7; cg_xlen = 3'd4;
              cg_exp = R1_IDLE; cg_rel = 1'b1; cg_k = K_C8;
            end else begin
              do_ifail = 1'b1; ifail_code = ST_RESET;
            end
          end
          K_C8: begin
            if (r == R1_IDLE) begin
              aleft_nxt = cfg.acmd_tries;
              do_cgo = 1'b1; cg_frame = F_CMD55; cg_len = 3'd7; cg_xlen = 3'd0;
              cg_exp = R1_READY; cg_rel = 1'b1; cg_k = K_C55;
            end else begin
              do_ifail = 1'b1; ifail_code = ST_CMD8;
            end
          end
          K_C55: begin
            if (r == R1_IDLE) begin
              do_cgo = 1'b1; cg_frame = F_ACMD41; cg_len = 3'd7; cg_xlen = 3'd0;
              cg_exp = R1_READY; cg_rel = 1'b1; cg_k = K_A41;
            end else do_anext = 1'b1;
          end
          K_A41: begin
            if (r == R1_READY) begin
              ocr_nxt = '0;
              do_cgo = 1'b1; cg_frame = F_CMD58; cg_len = 3'd7; cg_xlen = 3'd4;
              cg_exp = R1_READY; cg_rel = 1'b1; cg_k = K_C58;
            end else do_anext = 1'b1;
          end
          K_C58: begin
            if (r == R1_READY && ocr_nxt[6]) begin
              sdhc_nxt = 1'b1; do_tog = 1'b1; tg_lvl = 1'b1; tg_k = K_INIT_OK;
            end else begin
              do_cgo = 1'b1; cg_frame = F_CMD1; cg_len = 3'd6; cg_xlen = 3'd0;
              cg_exp = R1_READY; cg_rel = 1'b1; cg_k = K_C1;
            end
          end
          K_C1: begin
            if (r == R1_READY) begin
              sdhc_nxt = 1'b0; do_tog = 1'b1; tg_lvl = 1'b1; tg_k = K_INIT_OK;
            end else begin
              do_ifail = 1'b1; ifail_code = ST_IDENT;
            end
          end
          K_INIT_OK: begin
            slow_nxt = 1'b0; do_iend = 1'b1; iend_ok = 1'b1; iend_code = ST_OK;
          end
          K_RSEL: begin
            card_addr = sdhc_nxt ? addr_nxt : {addr_nxt[22:0], 9'd0};
            do_cgo = 1'b1; cg_frame = {8'h00, OP_CMD17, card_addr, 8'hFF}; cg_len = 3'd6;
            cg_xlen = 3'd0; cg_exp = R1_READY; cg_rel = 1'b0; cg_k = K_RCMD;
          end
          K_RCMD: begin
            if (r == R1_READY || r == R1_ADDRERR) begin
              wc_nxt = '0; ph_nxt = PH_TOKEN; emit = 1'b1;
            end else begin
              fail_nxt = ST_REJECTED; do_tog = 1'b1; tg_lvl = 1'b1; tg_k = K_RFAIL;
            end
          end
          K_RFAIL: do_rfail = 1'b1;
          K_REND: begin
            if (cfg.crc_en && crc_r != rcrc_r) begin
              fail_nxt = ST_CRC; do_rfail = 1'b1;
            end else begin
              cs_nxt = 1'b1; fin = 1'b1; fin_ok = 1'b1; fin_code = ST_OK;
            end
          end
          K_WCMD: begin
            if (r == R1_READY) begin
              bc_nxt = '0; ph_nxt = PH_WGAP; emit = 1'b1;
            end else begin
              fail_nxt = ST_REJECTED; do_tog = 1'b1; tg_lvl = 1'b1; tg_k = K_WFAIL;
            end
          end
          K_WFAIL: begin
            fin = 1'b1; fin_ok = 1'b0; fin_code = fail_nxt;
          end
          K_WEND: begin
            fin = 1'b1; fin_ok = busy_nxt; fin_code = ST_BUSY;
          end
          default: begin
            ph_nxt = PH_IDLE; op_nxt = OP_NONE;
          end
        endcase
      end

      if (do_anext) begin
        if (aleft_nxt > CNT_W'(1)) begin
          aleft_nxt = aleft_nxt - 1'b1;
          do_cgo = 1'b1; cg_frame = F_CMD55; cg_len = 3'd7; cg_xlen = 3'd0;
          cg_exp = R1_READY; cg_rel = 1'b1; cg_k = K_C55;
        end else begin
          do_ifail = 1'b1; ifail_code = ST_IDENT;
        end
      end
      if (do_ifail) begin
        att_nxt = att_r + 1'b1;
        if (att_nxt < cfg.init_tries) begin
          bc_nxt = '0; cs_nxt = 1'b1; ph_nxt = PH_PRE; emit = 1'b1;
        end else begin
          do_iend = 1'b1; iend_ok = 1'b0; iend_code = ifail_code;
        end
      end
      if (do_rfail) begin
        if (rleft_r != '0) begin
          rleft_nxt = rleft_r - 1'b1; do_tog = 1'b1; tg_lvl = 1'b0; tg_k = K_RSEL;
        end else begin
          // Out of read tries: run a full initialization again.
          att_nxt = '0; slow_nxt = 1'b1; bc_nxt = '0; cs_nxt = 1'b1;
          ph_nxt = PH_PRE; emit = 1'b1;
        end
      end
      if (do_iend) begin
        if (op_nxt == OP_INIT) begin
          fin = 1'b1; fin_ok = iend_ok; fin_code = iend_code;
        end else if (reinit_r >= 2'(REINIT_LIMIT)) begin
          cs_nxt = 1'b1; fin = 1'b1; fin_ok = 1'b0; fin_code = fail_nxt;
        end else begin
          reinit_nxt = reinit_r + 1'b1; rleft_nxt = cfg.read_retries;
          do_tog = 1'b1; tg_lvl = 1'b0; tg_k = K_RSEL;
        end
      end
      if (do_cgo) begin
        frame_nxt = cg_frame; flen_nxt = cg_len; xlen_nxt = cg_xlen; expect_nxt = cg_exp;
        rel_nxt = cg_rel; cret_nxt = cg_k; lr_nxt = BYTE_IDLE;
        cleft_nxt = CNT_W'(CMD_RETRIES);
        do_tog = 1'b1; tg_lvl = 1'b0; tg_k = K_CSEL;
      end
      if (do_tog) begin
        leaf_nxt = tg_k; tog_nxt = tg_lvl; ph_nxt = PH_TOG1; emit = 1'b1; emit_b = BYTE_IDLE;
      end
      if (fin) begin
        res.done_res = 1'b1; res.success = fin_ok; res.status_code = fin_ok ? ST_OK : fin_code;
        ph_nxt = PH_IDLE; op_nxt = OP_NONE;
      end
      if (emit) begin
        res.exchange_request = 1'b1; res.mosi_byte = emit_b;
      end
    end
    res.chip_select = cs_nxt; res.slow_clock = slow_nxt; res.card_is_sdhc = sdhc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_IDLE; bc_r <= '0; wc_r <= '0; att_r <= '0; reinit_r <= '0; sdhc_r <= 1'b0;
      frame_r <= '1; crc_r <= '0; rcrc_r <= '0; addr_r <= '0; lr_r <= BYTE_IDLE;
      op_r <= OP_NONE; leaf_r <= K_INIT_READY; cret_r <= K_INIT_READY; tog_r <= 1'b1;
      cs_r <= 1'b1; slow_r <= 1'b1; flen_r <= 3'd6; xlen_r <= '0; expect_r <= '0;
      rel_r <= 1'b0; cleft_r <= '0; aleft_r <= '0; rleft_r <= '0; ocr_r <= '0;
      fail_r <= '0; busy_r <= 1'b0;
    end else if (step) begin
      ph_r <= ph_nxt; bc_r <= bc_nxt; wc_r <= wc_nxt; att_r <= att_nxt;
      reinit_r <= reinit_nxt; sdhc_r <= sdhc_nxt; frame_r <= frame_nxt; crc_r <= crc_nxt;
      rcrc_r <= rcrc_nxt; addr_r <= addr_nxt; lr_r <= lr_nxt; op_r <= op_nxt;
      leaf_r <= leaf_nxt; cret_r <= cret_nxt; tog_r <= tog_nxt; cs_r <= cs_nxt;
      slow_r <= slow_nxt; flen_r <= flen_nxt; xlen_r <= xlen_nxt; expect_r <= expect_nxt;
      rel_r <= rel_nxt; cleft_r <= cleft_nxt; aleft_r <= aleft_nxt; rleft_r <= rleft_nxt;
      ocr_r <= ocr_nxt; fail_r <= fail_nxt; busy_r <= busy_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/sd_card_spi_host_controller_top.sv @@
// Top level of the SD card SPI host controller: config registers, handshake and result register.
//
//   Channel  Direction  Handshake                 Carries
//   in_      input      in_valid / in_ready       start command or finished SPI exchange
//   out_     output     out_valid / out_ready     next MOSI byte, line levels, data, status
//   cfg      input      APB psel/penable/pwrite   timeouts, try counts, CRC check enable
//
// Every accepted input beat yields exactly one result beat in the result register on the next cycle.
// A new input beat is taken in every cycle while the result register is empty
// or is being emptied in the same cycle; the sequencer's combinational next-state
// logic sets this rate of one beat per cycle. Reset (rst_n low, synchronous)
// idles the sequencer, deselects the card and selects the slow clock. A stalled
// result holds in the output register and stalls the input side.
`default_nettype none
`include "assert_macros.svh"
module sd_card_spi_host_controller_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [31:0] in_block_address,
  input  wire logic [7:0]  in_write_byte,
  input  wire logic [7:0]  in_miso_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_mosi_byte,
  output logic             out_exchange_request,
  output logic             out_chip_select,
  output logic             out_slow_clock,
  output logic             out_read_valid,
  output logic [7:0]       out_read_byte,
  output logic             out_write_request,
  output logic             out_done_res,
  output logic             out_success,
  output logic             out_card_is_sdhc,
  output logic [3:0]       out_status_code,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import sdh_pkg::*;

  cfg_t       cfg_r;
  res_t       res_nxt;
  res_t       out_r;
  logic       out_valid_r;
  logic       accept;
  logic [2:0] reg_idx;

  // Configuration registers, written at the access phase of an APB write.
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ready_to     <= 16'd500;
      cfg_r.resp_to      <= 16'd512;
      cfg_r.token_to     <= 17'd50000;
      cfg_r.busy_to      <= 17'd100000;
      cfg_r.init_tries   <= 7'd10;
      cfg_r.acmd_tries   <= 7'd5;
      cfg_r.read_retries <= 7'd10;
      cfg_r.crc_en       <= 1'b1;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_READY_TO:   cfg_r.ready_to     <= pwdata[15:0];
        REG_RESP_TO:    cfg_r.resp_to      <= pwdata[15:0];
        REG_TOKEN_TO:   cfg_r.token_to     <= pwdata[16:0];
        REG_BUSY_TO:    cfg_r.busy_to      <= pwdata[16:0];
        REG_INIT_TRIES: cfg_r.init_tries   <= pwdata[6:0];
        REG_ACMD_TRIES: cfg_r.acmd_tries   <= pwdata[6:0];
        REG_READ_RETRY: cfg_r.read_retries <= pwdata[6:0];
        REG_CRC_EN:     cfg_r.crc_en       <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_READY_TO:   prdata = {16'd0, cfg_r.ready_to};
      REG_RESP_TO:    prdata = {16'd0, cfg_r.resp_to};
      REG_TOKEN_TO:   prdata = {15'd0, cfg_r.token_to};
      REG_BUSY_TO:    prdata = {15'd0, cfg_r.busy_to};
      REG_INIT_TRIES: prdata = {25'd0, cfg_r.init_tries};
      REG_ACMD_TRIES: prdata = {25'd0, cfg_r.acmd_tries};
      REG_READ_RETRY: prdata = {25'd0, cfg_r.read_retries};
      REG_CRC_EN:     prdata = {31'd0, cfg_r.crc_en};
      default:        prdata = '0;
    endcase
  end

  // The input side is open whenever the result register is free this cycle.
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  sdh_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (accept),
    .cmd           (in_cmd),
    .block_address (in_block_address),
    .write_byte    (in_write_byte),
    .miso_byte     (in_miso_byte),
    .cfg           (cfg_r),
    .res           (res_nxt)
  );

  // Result register: loaded on every accepted beat, drained by out_ready.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_mosi_byte        = out_r.mosi_byte;
  assign out_exchange_request = out_r.exchange_request;
  assign out_chip_select      = out_r.chip_select;
  assign out_slow_clock       = out_r.slow_clock;
  assign out_read_valid       = out_r.read_valid;
  assign out_read_byte        = out_r.read_byte;
  assign out_write_request    = out_r.write_request;
  assign out_done_res         = out_r.done_res;
  assign out_success          = out_r.success;
  assign out_card_is_sdhc     = out_r.card_is_sdhc;
  assign out_status_code      = out_r.status_code;

  // Every accepted beat leaves a result in the output register.
  `ASSERT_NEXT(a_accept_gives_result, clk, rst_n, accept, out_valid_r)
  // A finished operation never asks for another exchange in the same beat.
  `ASSERT_IMPLIES(a_done_no_exchange, clk, rst_n, out_valid_r && out_r.done_res,
                  !out_r.exchange_request)
  // Sector data always comes with the request for the following exchange.
  `ASSERT_IMPLIES(a_read_with_exchange, clk, rst_n, out_valid_r && out_r.read_valid,
                  out_r.exchange_request)
  // A write start always begins with an exchange, never a completion.
  `ASSERT_NEXT(a_write_start_exchanges, clk, rst_n, accept && in_cmd == CMD_WRITE,
               out_r.exchange_request && !out_r.done_res)

endmodule
`default_nettype wire

@@ dv/sd_card_spi_host_controller_tb.sv @@
// Self-checking testbench for the SD card SPI host controller, with its own sequencer model.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sdh_pkg::*;

  localparam int unsigned STALL_LIMIT   = 4000;
  localparam int unsigned HOLD_AT_BEAT  = 300;
  localparam int unsigned HOLD_CYCLES   = 90;
  localparam int unsigned PHASE_BEATS   = 300;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_cmd;
  logic [31:0] in_block_address;
  logic [7:0]  in_write_byte;
  logic [7:0]  in_miso_byte;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_mosi_byte;
  logic        out_exchange_request;
  logic        out_chip_select;
  logic        out_slow_clock;
  logic        out_read_valid;
  logic [7:0]  out_read_byte;
  logic        out_write_request;
  logic        out_done_res;
  logic        out_success;
  logic        out_card_is_sdhc;
  logic [3:0]  out_status_code;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  sd_card_spi_host_controller_top dut (.*);

  // The clock runs at 125 MHz: 4 ns high, 4 ns low.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Sequencer model. It mirrors the controller one beat at a time: every
  // accepted input beat is run through it and yields the one result beat the
  // block must return. Its counters cnt_byte, cnt_wait, cnt_attempt and cnt_reinit are kept at the block's own widths.
  // ---------------------------------------------------------------------------
  phase_t      seq_phase;
  logic [9:0]  cnt_byte;
  logic [16:0] cnt_wait;
  logic [6:0]  cnt_attempt;
  logic [1:0]  cnt_reinit;
  logic        sdhc;
  logic [55:0] cmd_frame;
  logic [15:0] crc_acc;
  logic [15:0] crc_rx;
  logic [31:0] addr_reg;
  logic [7:0]  r1_last;

  // Shadow copy of the configuration registers.
  logic [15:0] cfg_ready_to;
  logic [15:0] cfg_resp_to;
  logic [16:0] cfg_token_to;
  logic [16:0] cfg_busy_to;
  logic [6:0]  cfg_init_tries;
  logic [6:0]  cfg_acmd_tries;
  logic [6:0]  cfg_read_retries;
  logic        cfg_crc_en;

  op_t         cur_op;
  key_t        leaf_key;
  key_t        cmd_key;
  logic        toggle_level;
  logic        cs_level;
  logic        slow_level;
  int unsigned frame_len;
  int unsigned extra_len;
  logic [7:0]  r1_wanted;
  logic        release_after;
  int unsigned cmd_left;
  int unsigned acmd_left;
  int unsigned read_left;
  logic [7:0]  ocr_byte;
  logic [3:0]  fail_code;
  logic        ready_seen;
  logic        busy_cleared;
  logic [7:0]  data_in;
  res_t        beat;

  // A finished step that hands control back to a waiting caller is queued
  // here and resolved by a loop, which keeps the model free of recursion.
  logic        resume_due;
  key_t        resume_key;

  function automatic void model_reset();
    seq_phase = PH_IDLE;  cnt_byte = '0;  cnt_wait = '0;  cnt_attempt = '0;
    cnt_reinit = '0;  sdhc = 1'b0;  cmd_frame = '1;  crc_acc = '0;  crc_rx = '0;
    addr_reg = '0;  r1_last = BYTE_IDLE;
    cfg_ready_to = 16'd500;  cfg_resp_to = 16'd512;  cfg_token_to = 17'd50000;
    cfg_busy_to = 17'd100000;  cfg_init_tries = 7'd10;  cfg_acmd_tries = 7'd5;
    cfg_read_retries = 7'd10;  cfg_crc_en = 1'b1;
    cur_op = OP_NONE;  leaf_key = K_INIT_READY;  cmd_key = K_INIT_READY;
    toggle_level = 1'b1;  cs_level = 1'b1;  slow_level = 1'b1;
    frame_len = 6;  extra_len = 0;  r1_wanted = 8'h00;  release_after = 1'b0;
    cmd_left = 0;  acmd_left = 0;  read_left = 0;  ocr_byte = '0;  fail_code = ST_OK;
    ready_seen = 1'b0;  busy_cleared = 1'b0;  data_in = '0;  resume_due = 1'b0;
  endfunction

  function automatic void defer_to(key_t k);
    resume_due = 1'b1;
    resume_key = k;
  endfunction

  function automatic void shift_out(logic [7:0] b);
    beat.mosi_byte = b;
    beat.exchange_request = 1'b1;
  endfunction

  function automatic void end_operation(logic ok, logic [3:0] code);
    beat.done_res = 1'b1;
    beat.success = ok;
    beat.status_code = ok ? ST_OK : code;
    seq_phase = PH_IDLE;
    cur_op = OP_NONE;
  endfunction

  function automatic void toggle_cs(logic level, key_t k);
    leaf_key = k;
    toggle_level = level;
    seq_phase = PH_TOG1;
    shift_out(BYTE_IDLE);
  endfunction

  function automatic void await_ready(key_t k);
    leaf_key = k;
    cnt_wait = '0;
    seq_phase = PH_READY;
    shift_out(BYTE_IDLE);
  endfunction

  function automatic logic [7:0] frame_byte_at(int unsigned i);
    int unsigned sh;
    sh = 8 * ((frame_len - 1 - i) & 7);
    return 8'(cmd_frame >> sh);
  endfunction

  function automatic void command_end();
    if (release_after) toggle_cs(1'b1, K_CREL);
    else defer_to(cmd_key);
  endfunction

  function automatic void command_next();
    if (cmd_left > 1) begin
      cmd_left--;
      toggle_cs(1'b0, K_CSEL);
    end else begin
      command_end();
    end
  endfunction

  function automatic void command_issue(logic [55:0] frame, int unsigned len,
                                        int unsigned extra, logic [7:0] wanted,
                                        logic rel, key_t k);
    cmd_frame = frame;  frame_len = len;  extra_len = extra;  r1_wanted = wanted;
    release_after = rel;  cmd_key = k;  r1_last = BYTE_IDLE;  cmd_left = CMD_RETRIES;
    toggle_cs(1'b0, K_CSEL);
  endfunction

  function automatic logic [31:0] card_addr();
    return sdhc ? addr_reg : {addr_reg[22:0], 9'd0};
  endfunction

  function automatic void init_attempt();
    cnt_byte = '0;
    cs_level = 1'b1;
    seq_phase = PH_PRE;
    shift_out(BYTE_IDLE);
  endfunction

  function automatic void init_begin();
    cnt_attempt = '0;
    slow_level = 1'b1;
    init_attempt();
  endfunction

  // Init either stands alone or repairs a failing read; in the latter case
  // the read restarts until the re-initialization budget is used up.
  function automatic void init_finish(logic ok, logic [3:0] code);
    if (cur_op == OP_INIT) begin
      end_operation(ok, code);
    end else if (cnt_reinit >= REINIT_LIMIT) begin
      cs_level = 1'b1;
      end_operation(1'b0, fail_code);
    end else begin
      cnt_reinit++;
      read_left = cfg_read_retries;
      toggle_cs(1'b0, K_RSEL);
    end
  endfunction

  function automatic void init_failed(logic [3:0] code);
    cnt_attempt++;
    if (cnt_attempt < cfg_init_tries) init_attempt();
    else init_finish(1'b0, code);
  endfunction

  function automatic void acmd_retry();
    if (acmd_left > 1) begin
      acmd_left--;
      command_issue(F_CMD55, 7, 0, R1_READY, 1'b1, K_C55);
    end else begin
      init_failed(ST_IDENT);
    end
  endfunction

  function automatic void read_failed();
    if (read_left > 0) begin
      read_left--;
      toggle_cs(1'b0, K_RSEL);
    end else begin
      init_begin();
    end
  endfunction

  function automatic void continue_at(key_t k);
    logic [7:0] r;
    r = r1_last;
    case (k)
      K_INIT_READY: if (ready_seen) toggle_cs(1'b0, K_INIT_SEL);
                    else init_failed(ST_NOT_READY);
      K_INIT_SEL:   command_issue(F_CMD0, 6, 0, R1_IDLE, 1'b1, K_C0);
      K_C0:         if (r == R1_IDLE) command_issue(F_CMD8, 7, 4, R1_IDLE, 1'b1, K_C8);
                    else init_failed(ST_RESET);
      K_C8: begin
        if (r == R1_IDLE) begin
          acmd_left = cfg_acmd_tries;
          command_issue(F_CMD55, 7, 0, R1_READY, 1'b1, K_C55);
        end else begin
          init_failed(ST_CMD8);
        end
      end
      K_C55:        if (r == R1_IDLE) command_issue(F_ACMD41, 7, 0, R1_READY, 1'b1, K_A41);
                    else acmd_retry();
      K_A41: begin
        if (r == R1_READY) begin
          ocr_byte = '0;
          command_issue(F_CMD58, 7, 4, R1_READY, 1'b1, K_C58);
        end else begin
          acmd_retry();
        end
      end
      K_C58: begin
        // A card that reports block addressing in the OCR skips CMD1.
        if (r == R1_READY && ocr_byte[6]) begin
          sdhc = 1'b1;
          toggle_cs(1'b1, K_INIT_OK);
        end else begin
          command_issue(F_CMD1, 6, 0, R1_READY, 1'b1, K_C1);
        end
      end
      K_C1: begin
        if (r == R1_READY) begin
          sdhc = 1'b0;
          toggle_cs(1'b1, K_INIT_OK);
        end else begin
          init_failed(ST_IDENT);
        end
      end
      K_INIT_OK: begin
        slow_level = 1'b0;
        init_finish(1'b1, ST_OK);
      end
      K_CSEL:       await_ready(K_CREADY);
      K_CREADY: begin
        if (ready_seen) begin
          cnt_byte = '0;
          seq_phase = PH_FRAME;
          shift_out(frame_byte_at(0));
        end else begin
          cs_level = 1'b1;
          command_next();
        end
      end
      K_CREL:       defer_to(cmd_key);
      K_RSEL:       command_issue({8'h00, OP_CMD17, card_addr(), 8'hFF}, 6, 0, R1_READY,
                                  1'b0, K_RCMD);
      K_RCMD: begin
        if (r == R1_READY || r == R1_ADDRERR) begin
          cnt_wait = '0;
          seq_phase = PH_TOKEN;
          shift_out(BYTE_IDLE);
        end else begin
          fail_code = ST_REJECTED;
          toggle_cs(1'b1, K_RFAIL);
        end
      end
      K_RFAIL:      read_failed();
      K_REND: begin
        if (cfg_crc_en && crc_acc != crc_rx) begin
          fail_code = ST_CRC;
          read_failed();
        end else begin
          cs_level = 1'b1;
          end_operation(1'b1, ST_OK);
        end
      end
      K_WCMD: begin
        if (r == R1_READY) begin
          cnt_byte = '0;
          seq_phase = PH_WGAP;
          shift_out(BYTE_IDLE);
        end else begin
          fail_code = ST_REJECTED;
          toggle_cs(1'b1, K_WFAIL);
        end
      end
      K_WFAIL:      end_operation(1'b0, fail_code);
      K_WEND:       end_operation(busy_cleared, ST_BUSY);
      default: begin
        seq_phase = PH_IDLE;
        cur_op = OP_NONE;
      end
    endcase
  endfunction

  function automatic void crc_update(logic [7:0] b);
    logic [15:0] c;
    c = crc_acc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
    crc_acc = c;
  endfunction

  function automatic void write_data_byte();
    if (cnt_byte < SECTOR_BYTES) begin
      shift_out(data_in);
      cnt_byte++;
      if (cnt_byte < SECTOR_BYTES) beat.write_request = 1'b1;
    end else begin
      cnt_byte = 10'd1;
      seq_phase = PH_WCRC;
      shift_out(BYTE_IDLE);
    end
  endfunction

  function automatic void on_exchange(logic [7:0] m);
    case (seq_phase)
      PH_PRE: begin
        cnt_byte++;
        if (cnt_byte < PRESIGNAL_BYTES) shift_out(BYTE_IDLE);
        else await_ready(K_INIT_READY);
      end
      PH_READY: begin
        cnt_wait++;
        if (m == BYTE_IDLE) begin
          ready_seen = 1'b1;
          defer_to(leaf_key);
        end else if (cnt_wait >= cfg_ready_to) begin
          ready_seen = 1'b0;
          defer_to(leaf_key);
        end else begin
          shift_out(BYTE_IDLE);
        end
      end
      PH_TOG1: begin
        cs_level = toggle_level;
        seq_phase = PH_TOG2;
        shift_out(BYTE_IDLE);
      end
      PH_TOG2: defer_to(leaf_key);
      PH_FRAME: begin
        cnt_byte++;
        if (cnt_byte < frame_len) begin
          shift_out(frame_byte_at(cnt_byte));
        end else begin
          cnt_wait = '0;
          seq_phase = PH_RESP;
          shift_out(BYTE_IDLE);
        end
      end
      PH_RESP: begin
        cnt_wait++;
        if (m != BYTE_IDLE) begin
          r1_last = m;
          if (extra_len != 0) begin
            cnt_byte = '0;
            seq_phase = PH_EXTRA;
            shift_out(BYTE_IDLE);
          end else if (m == r1_wanted) begin
            command_end();
          end else begin
            command_next();
          end
        end else if (cnt_wait >= cfg_resp_to) begin
          // A silent card counts as R1 0xFF and ends the retry loop.
          r1_last = BYTE_IDLE;
          command_end();
        end else begin
          shift_out(BYTE_IDLE);
        end
      end
      PH_EXTRA: begin
        if (cnt_byte == 0) ocr_byte = m;
        cnt_byte++;
        if (cnt_byte < extra_len) shift_out(BYTE_IDLE);
        else if (r1_last == r1_wanted) command_end();
        else command_next();
      end
      PH_TOKEN: begin
        cnt_wait++;
        if (m == BYTE_TOKEN) begin
          cnt_byte = '0;
          crc_acc = '0;
          seq_phase = PH_RDATA;
          shift_out(BYTE_IDLE);
        end else if (cnt_wait >= cfg_token_to) begin
          fail_code = ST_TOKEN;
          toggle_cs(1'b1, K_RFAIL);
        end else begin
          shift_out(BYTE_IDLE);
        end
      end
      PH_RDATA: begin
        beat.read_valid = 1'b1;
        beat.read_byte = m;
        crc_update(m);
        cnt_byte++;
        if (cnt_byte >= SECTOR_BYTES) begin
          cnt_byte = '0;
          crc_rx = '0;
          seq_phase = PH_RCRC;
        end
        shift_out(BYTE_IDLE);
      end
      PH_RCRC: begin
        crc_rx = {crc_rx[7:0], m};
        cnt_byte++;
        if (cnt_byte < 2) shift_out(BYTE_IDLE);
        else toggle_cs(1'b1, K_REND);
      end
      PH_WGAP: begin
        // One gap byte, then the start token; the first data byte follows.
        if (cnt_byte == 0) begin
          cnt_byte = 10'd1;
          shift_out(BYTE_TOKEN);
          beat.write_request = 1'b1;
        end else begin
          cnt_byte = '0;
          seq_phase = PH_WDATA;
          write_data_byte();
        end
      end
      PH_WDATA: write_data_byte();
      PH_WCRC: begin
        if (cnt_byte < 3) begin
          cnt_byte++;
          shift_out(BYTE_IDLE);
        end else begin
          cnt_wait = '0;
          seq_phase = PH_BUSY;
          shift_out(BYTE_IDLE);
        end
      end
      PH_BUSY: begin
        cnt_wait++;
        if (m != 8'h00) begin
          busy_cleared = 1'b1;
          toggle_cs(1'b1, K_WEND);
        end else if (cnt_wait >= cfg_busy_to) begin
          busy_cleared = 1'b0;
          toggle_cs(1'b1, K_WEND);
        end else begin
          shift_out(BYTE_IDLE);
        end
      end
      default: seq_phase = PH_IDLE;
    endcase
  endfunction

  function automatic res_t next_card_result(logic [1:0] cmd, logic [31:0] addr,
                                            logic [7:0] wb, logic [7:0] miso);
    beat = '0;
    data_in = wb;
    case (cmd)
      CMD_INIT: begin
        cur_op = OP_INIT;
        init_begin();
      end
      CMD_READ: begin
        cur_op = OP_READ;
        addr_reg = addr;
        cs_level = 1'b0;
        read_left = cfg_read_retries;
        cnt_reinit = '0;
        toggle_cs(1'b0, K_RSEL);
      end
      CMD_WRITE: begin
        cur_op = OP_WRITE;
        addr_reg = addr;
        command_issue({8'hFF, OP_CMD24, card_addr(), 8'hFF}, 7, 0, R1_READY, 1'b0, K_WCMD);
      end
      default: if (seq_phase != PH_IDLE) on_exchange(miso);
    endcase
    while (resume_due) begin
      resume_due = 1'b0;
      continue_at(resume_key);
    end
    beat.chip_select = cs_level;
    beat.slow_clock = slow_level;
    beat.card_is_sdhc = sdhc;
    return beat;
  endfunction

  // ---------------------------------------------------------------------------
  // Card emulation. While an operation runs, the MISO byte of each exchange is
  // chosen from the model's current phase. A cooperative card mostly answers
  // what moves the sequence forward; an unruly one answers noise, so timeouts,
  // rejections and CRC errors come up as well.
  // ---------------------------------------------------------------------------
  logic cooperative;

  function automatic logic [7:0] wanted_reply();
    case (cmd_key)
      K_C0, K_C8, K_C55: return R1_IDLE;
      K_RCMD:            return ($urandom_range(0, 1) != 0) ? R1_READY : R1_ADDRERR;
      default:           return R1_READY;
    endcase
  endfunction

  function automatic logic [7:0] card_reply();
    int unsigned pct;
    logic [7:0]  noise;
    pct = $urandom_range(0, 99);
    noise = 8'($urandom_range(0, 255));
    case (seq_phase)
      PH_READY: return (cooperative || pct < 50) ? BYTE_IDLE : noise;
      PH_RESP: begin
        if (cooperative) return (pct < 60) ? wanted_reply() : BYTE_IDLE;
        return (pct < 50) ? BYTE_IDLE : noise;
      end
      PH_TOKEN: begin
        if (cooperative) return (pct < 50) ? BYTE_TOKEN : BYTE_IDLE;
        return (pct < 15) ? BYTE_TOKEN : noise;
      end
      PH_RCRC: begin
        if (pct < (cooperative ? 90 : 50)) return (cnt_byte == 0) ? crc_acc[15:8] : crc_acc[7:0];
        return noise;
      end
      PH_BUSY: begin
        if (pct < (cooperative ? 60 : 50)) return 8'h00;
        return cooperative ? 8'($urandom_range(1, 255)) : noise;
      end
      default: return noise;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sender, receiver and result checking.
  // ---------------------------------------------------------------------------
  res_t        expected_results[$];
  int unsigned errors;
  int unsigned beats_sent;
  int unsigned beats_seen;
  int unsigned ok_count[op_t];
  int unsigned fail_count;
  op_t         started_op;
  logic        burst_tx;
  logic        burst_rx;

  task automatic send_beat(logic [1:0] cmd, logic [31:0] addr, logic [7:0] wb,
                           logic [7:0] miso, logic typed, res_t typed_res);
    int unsigned gap;
    res_t        predicted;
    if (beats_sent % 64 == 0) burst_tx = ($urandom_range(0, 3) == 0);
    gap = burst_tx ? 0 : $urandom_range(0, 6);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_cmd <= cmd;
    in_block_address <= addr;
    in_write_byte <= wb;
    in_miso_byte <= miso;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    // Exchange beats that reach an idle sequencer do nothing and are not counted.
    if (!(cmd == CMD_EXCH && seq_phase == PH_IDLE)) beats_sent++;
    if (cmd != CMD_EXCH) started_op = op_t'(cmd);
    predicted = next_card_result(cmd, addr, wb, miso);
    if (predicted.done_res) begin
      if (predicted.success) ok_count[started_op]++;
      else fail_count++;
    end
    expected_results.push_back(typed ? typed_res : predicted);
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  initial begin
    int unsigned gap;
    res_t        exp_r;
    out_ready = 1'b0;
    burst_rx = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (beats_seen % 50 == 0) burst_rx = ($urandom_range(0, 3) == 0);
      gap = burst_rx ? 0 : $urandom_range(0, 6);
      // One long hold-off lets the result register fill and stall the input.
      if (beats_seen == HOLD_AT_BEAT) gap = HOLD_CYCLES;
      @(negedge clk);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      beats_seen++;
      if (expected_results.size() == 0) begin
        $error("result beat arrived with nothing expected");
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        check_field("mosi_byte", exp_r.mosi_byte, out_mosi_byte);
        check_field("exchange_request", exp_r.exchange_request, out_exchange_request);
        check_field("chip_select", exp_r.chip_select, out_chip_select);
        check_field("slow_clock", exp_r.slow_clock, out_slow_clock);
        check_field("read_valid", exp_r.read_valid, out_read_valid);
        check_field("read_byte", exp_r.read_byte, out_read_byte);
        check_field("write_request", exp_r.write_request, out_write_request);
        check_field("done_res", exp_r.done_res, out_done_res);
        check_field("success", exp_r.success, out_success);
        check_field("card_is_sdhc", exp_r.card_is_sdhc, out_card_is_sdhc);
        check_field("status_code", exp_r.status_code, out_status_code);
      end
    end
  end

  // Watchdog: a run in which neither channel nor the register port moves for
  // this long has hung.
  int unsigned stall_cycles;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Registers change only once every expected result is back, so the block
  // and the model switch settings at the same point in the beat stream.
  task automatic reg_write(logic [2:0] idx, logic [31:0] value);
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_READY_TO:   cfg_ready_to = value[15:0];
      REG_RESP_TO:    cfg_resp_to = value[15:0];
      REG_TOKEN_TO:   cfg_token_to = value[16:0];
      REG_BUSY_TO:    cfg_busy_to = value[16:0];
      REG_INIT_TRIES: cfg_init_tries = value[6:0];
      REG_ACMD_TRIES: cfg_acmd_tries = value[6:0];
      REG_READ_RETRY: cfg_read_retries = value[6:0];
      default:        cfg_crc_en = value[0];
    endcase
  endtask

  task automatic set_all_regs(logic [31:0] rdy, logic [31:0] rsp, logic [31:0] tok,
                              logic [31:0] bsy, logic [31:0] itr, logic [31:0] atr,
                              logic [31:0] rtr, logic [31:0] crc);
    reg_write(REG_READY_TO, rdy);
    reg_write(REG_RESP_TO, rsp);
    reg_write(REG_TOKEN_TO, tok);
    reg_write(REG_BUSY_TO, bsy);
    reg_write(REG_INIT_TRIES, itr);
    reg_write(REG_ACMD_TRIES, atr);
    reg_write(REG_READ_RETRY, rtr);
    reg_write(REG_CRC_EN, crc);
  endtask

  function automatic logic [1:0] pick_operation();
    int unsigned k;
    k = $urandom_range(0, 9);
    if (k == 0) return CMD_INIT;
    return (k < 6) ? CMD_READ : CMD_WRITE;
  endfunction

  // Random traffic: whole operations against the emulated card, with stray
  // exchanges to an idle block and the odd restart in the middle of one.
  // An operation still running at the end of a phase carries on in the next.
  task automatic run_traffic(int unsigned target, logic all_cooperative);
    int unsigned first;
    first = beats_sent;
    forever begin
      if (beats_sent - first >= target) break;
      if (seq_phase == PH_IDLE) begin
        if ($urandom_range(0, 7) == 0) begin
          send_beat(CMD_EXCH, $urandom, 8'($urandom), 8'($urandom), 1'b0, '0);
        end else begin
          cooperative = all_cooperative || ($urandom_range(0, 9) < 6);
          send_beat(pick_operation(), $urandom, 8'($urandom), 8'($urandom), 1'b0, '0);
        end
      end else if ($urandom_range(0, 999) == 0) begin
        cooperative = all_cooperative || ($urandom_range(0, 9) < 6);
        send_beat(pick_operation(), $urandom, 8'($urandom), 8'($urandom), 1'b0, '0);
      end else begin
        send_beat(CMD_EXCH, $urandom, 8'($urandom), card_reply(), 1'b0, '0);
      end
    end
  endtask

  // Directed rows. Expected results are typed in only where they follow at
  // once from reset; the other rows are checked against the model.
  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] addr;
    logic [7:0]  wb;
    logic [7:0]  miso;
    logic        typed;
    res_t        res;
  } stim_row_t;

  localparam res_t IDLE_AFTER_RESET = '{mosi_byte: 8'h00, exchange_request: 1'b0,
      chip_select: 1'b1, slow_clock: 1'b1, read_valid: 1'b0, read_byte: 8'h00,
      write_request: 1'b0, done_res: 1'b0, success: 1'b0, card_is_sdhc: 1'b0,
      status_code: ST_OK};
  localparam res_t INIT_FIRST_BYTE = '{mosi_byte: BYTE_IDLE, exchange_request: 1'b1,
      chip_select: 1'b1, slow_clock: 1'b1, read_valid: 1'b0, read_byte: 8'h00,
      write_request: 1'b0, done_res: 1'b0, success: 1'b0, card_is_sdhc: 1'b0,
      status_code: ST_OK};

  stim_row_t directed[] = '{
    // Exchanges to an idle block are ignored.
    '{CMD_EXCH,  32'h0000_0000, 8'h00, 8'h00, 1'b1, IDLE_AFTER_RESET},
    '{CMD_EXCH,  32'hFFFF_FFFF, 8'hFF, 8'hFF, 1'b1, IDLE_AFTER_RESET},
    '{CMD_INIT,  32'hFFFF_FFFF, 8'hFF, 8'hFF, 1'b1, INIT_FIRST_BYTE},
    '{CMD_EXCH,  32'h0000_0000, 8'h00, 8'hFF, 1'b0, '0},
    '{CMD_EXCH,  32'h0000_0000, 8'h00, 8'h00, 1'b0, '0},
    '{CMD_EXCH,  32'h0000_0000, 8'h00, 8'hFE, 1'b0, '0},
    // Starts while busy drop the running operation.
    '{CMD_READ,  32'hFFFF_FFFF, 8'h00, 8'h00, 1'b0, '0},
    '{CMD_EXCH,  32'h0000_0000, 8'h00, 8'h00, 1'b0, '0},
    '{CMD_EXCH,  32'h0000_0000, 8'h00, 8'hFF, 1'b0, '0},
    '{CMD_EXCH,  32'h0000_0000, 8'h00, 8'hFF, 1'b0, '0},
    '{CMD_WRITE, 32'h0000_0000, 8'hFF, 8'hFF, 1'b0, '0},
    '{CMD_EXCH,  32'h0000_0000, 8'hA5, 8'hFF, 1'b0, '0},
    '{CMD_EXCH,  32'hFFFF_FFFF, 8'h5A, 8'hFF, 1'b0, '0},
    '{CMD_WRITE, 32'h8000_0001, 8'h00, 8'h00, 1'b0, '0},
    '{CMD_EXCH,  32'h0000_0000, 8'h00, 8'h01, 1'b0, '0},
    '{CMD_READ,  32'h0000_0000, 8'h00, 8'hFF, 1'b0, '0},
    '{CMD_EXCH,  32'h0000_0000, 8'h00, 8'hFF, 1'b0, '0},
    '{CMD_INIT,  32'h0000_0000, 8'h00, 8'h00, 1'b0, '0},
    '{CMD_EXCH,  32'h0000_0000, 8'h00, 8'h80, 1'b0, '0}
  };

  initial begin
    model_reset();
    errors = 0;  beats_sent = 0;  beats_seen = 0;  fail_count = 0;
    started_op = OP_NONE;  burst_tx = 1'b0;  cooperative = 1'b1;
    ok_count[OP_INIT] = 0;  ok_count[OP_READ] = 0;  ok_count[OP_WRITE] = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;  in_cmd = CMD_EXCH;  in_block_address = '0;
    in_write_byte = '0;  in_miso_byte = '0;
    psel = 1'b0;  penable = 1'b0;  pwrite = 1'b0;  paddr = '0;  pwdata = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i])
      send_beat(directed[i].cmd, directed[i].addr, directed[i].wb, directed[i].miso,
                directed[i].typed, directed[i].res);

    // Smallest settings: single tries, no read retry, CRC check off.
    set_all_regs(1, 1, 1, 1, 1, 1, 0, 0);
    run_traffic(PHASE_BEATS, 1'b0);

    // Largest settings, against a card that always cooperates so that the
    // long timeouts are never waited out.
    set_all_regs(65535, 65535, 131071, 131071, 127, 127, 127, 1);
    run_traffic(PHASE_BEATS, 1'b1);

    // Short random settings so that every timeout and retry path is hit.
    repeat (3) begin
      set_all_regs($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(1, 8),
                   $urandom_range(1, 8), $urandom_range(1, 3), $urandom_range(1, 3),
                   $urandom_range(0, 2), $urandom_range(0, 1));
      run_traffic(PHASE_BEATS, 1'b0);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d working beats over five register settings, checked %0d results.",
             beats_sent, beats_seen);
    $display("Completed %0d inits, %0d reads, %0d writes successfully; %0d ended in error.",
             ok_count[OP_INIT], ok_count[OP_READ], ok_count[OP_WRITE], fail_count);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
